// ===== hdl/smfs_pkg.sv =====
package smfs_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [3:0] TEMPO_LEN = 4'd7;
  localparam logic [3:0] END_LEN   = 4'd4;

  localparam logic [3:0] FAMILY_CTRL     = 4'hB;
  localparam logic [3:0] FAMILY_PROGRAM  = 4'hC;
  localparam logic [3:0] FAMILY_PRESSURE = 4'hD;

  localparam logic [15:0] CTRL_SKIP_A = 16'h0070;
  localparam logic [15:0] CTRL_SKIP_B = 16'h0071;
  localparam logic [15:0] CTRL_SKIP_C = 16'h0072;

  typedef enum logic [1:0] {
    MODE_EVENT = 2'd0,
    MODE_START = 2'd1,
    MODE_END   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_EVENT = 2'd1,
    CMD_END   = 2'd2
  } cmd_kind_t;

  // one queued request, already classified for the byte writer
  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] delta;
    logic [2:0]  vlq_len;
    logic [7:0]  status;
    logic [6:0]  data1;
    logic [6:0]  data2;
    logic        two_data;
  } cmd_t;

  function automatic logic [7:0] tempo_byte(input logic [2:0] i);
    logic [7:0] b;
    unique case (i)
      3'd0:    b = 8'h00;
      3'd1:    b = 8'hFF;
      3'd2:    b = 8'h51;
      3'd3:    b = 8'h03;
      3'd4:    b = 8'h0F;
      3'd5:    b = 8'h42;
      3'd6:    b = 8'h40;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] end_byte(input logic [1:0] i);
    logic [7:0] b;
    unique case (i)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'hFF;
      2'd2:    b = 8'h2F;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/smfs_evt_if.sv =====
interface smfs_evt_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] tick;
  logic [7:0]  status;
  logic [15:0] data1;
  logic [15:0] data2;

  modport source (output valid, mode, tick, status, data1, data2, input ready);
  modport sink   (input valid, mode, tick, status, data1, data2, output ready);
endinterface

// ===== hdl/smfs_trk_if.sv =====
interface smfs_trk_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last;
  logic [31:0] track_bytes;

  modport source (output valid, out_byte, last, track_bytes, input ready);
  modport sink   (input valid, out_byte, last, track_bytes, output ready);
endinterface

// ===== hdl/smfs_front.sv =====
module smfs_front (
  input  logic           clk,
  input  logic           rst,
  smfs_evt_if.sink       evt,
  output logic           push_valid,
  output smfs_pkg::cmd_t push_data,
  input  logic           push_ready
);

  logic [31:0] prev_tick;
  logic        seen;
  logic        accept;
  logic        skip_ctrl;
  logic        keep;
  logic [31:0] delta;

  assign evt.ready = push_ready;
  assign accept    = evt.valid && push_ready;

  assign skip_ctrl = (evt.status[7:4] == smfs_pkg::FAMILY_CTRL) &&
                     ((evt.data1 == smfs_pkg::CTRL_SKIP_A) ||
                      (evt.data1 == smfs_pkg::CTRL_SKIP_B) ||
                      (evt.data1 == smfs_pkg::CTRL_SKIP_C));

  // only the low 32 bits of the tick matter after truncation
  assign delta = seen ? (evt.tick[31:0] - prev_tick) : 32'd0;

  always_comb begin
    keep                = 1'b0;
    push_data.kind      = smfs_pkg::CMD_EVENT;
    push_data.delta     = delta;
    push_data.status    = evt.status;
    push_data.data1     = evt.data1[6:0];
    push_data.data2     = evt.data2[6:0];
    push_data.two_data  = (evt.status[7:4] != smfs_pkg::FAMILY_PROGRAM) &&
                          (evt.status[7:4] != smfs_pkg::FAMILY_PRESSURE);
    priority if (delta[31:28] != 4'd0) push_data.vlq_len = 3'd5;
    else if (delta[27:21] != 7'd0)     push_data.vlq_len = 3'd4;
    else if (delta[20:14] != 7'd0)     push_data.vlq_len = 3'd3;
    else if (delta[13:7] != 7'd0)      push_data.vlq_len = 3'd2;
    else                               push_data.vlq_len = 3'd1;
    unique case (evt.mode)
      smfs_pkg::MODE_START: begin
        keep           = 1'b1;
        push_data.kind = smfs_pkg::CMD_START;
      end
      smfs_pkg::MODE_END: begin
        keep           = 1'b1;
        push_data.kind = smfs_pkg::CMD_END;
      end
      smfs_pkg::MODE_EVENT: begin
        keep           = !skip_ctrl;
        push_data.kind = smfs_pkg::CMD_EVENT;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push_valid = evt.valid && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= 1'b0;
      prev_tick <= 32'd0;
    end else if (accept) begin
      if (evt.mode == smfs_pkg::MODE_START) begin
        seen      <= 1'b0;
        prev_tick <= 32'd0;
      end else if ((evt.mode == smfs_pkg::MODE_EVENT) && !skip_ctrl) begin
        seen      <= 1'b1;
        prev_tick <= evt.tick[31:0];
      end
    end
  end

endmodule

// ===== hdl/smfs_queue.sv =====
module smfs_queue #(
  parameter int DEPTH = smfs_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  input  smfs_pkg::cmd_t push_data,
  output logic           push_ready,
  output logic           pop_valid,
  output smfs_pkg::cmd_t pop_data,
  input  logic           pop_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  smfs_pkg::cmd_t slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  a_fill_up: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == CW'($past(count) + 1'b1)))
    else $error("queue count did not rise on a lone push");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == CW'($past(count) - 1'b1)))
    else $error("queue count did not fall on a lone pop");

endmodule

// ===== hdl/smfs_back.sv =====
module smfs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  input  smfs_pkg::cmd_t pop_data,
  output logic           pop_ready,
  smfs_trk_if.source     trk
);

  smfs_pkg::cmd_t cur;
  logic           busy;
  logic [3:0]     idx;
  logic [31:0]    cnt;
  logic           ov;
  logic [7:0]     obyte;
  logic           olast;

  logic [3:0]  len;
  logic [7:0]  byte_val;
  logic        final_byte;
  logic        adv;
  logic        emit;
  logic        take;
  logic [31:0] base;
  logic [2:0]  grp_sel;
  logic [6:0]  grp;
  logic [3:0]  tail_idx;

  assign trk.valid       = ov;
  assign trk.out_byte    = obyte;
  assign trk.last        = olast;
  assign trk.track_bytes = cnt;

  always_comb begin
    grp_sel  = cur.vlq_len - 3'd1 - idx[2:0];
    tail_idx = idx - {1'b0, cur.vlq_len};
    unique case (grp_sel)
      3'd0:    grp = cur.delta[6:0];
      3'd1:    grp = cur.delta[13:7];
      3'd2:    grp = cur.delta[20:14];
      3'd3:    grp = cur.delta[27:21];
      default: grp = {3'd0, cur.delta[31:28]};
    endcase
    unique case (cur.kind)
      smfs_pkg::CMD_START: begin
        len      = smfs_pkg::TEMPO_LEN;
        byte_val = smfs_pkg::tempo_byte(idx[2:0]);
      end
      smfs_pkg::CMD_END: begin
        len      = smfs_pkg::END_LEN;
        byte_val = smfs_pkg::end_byte(idx[1:0]);
      end
      smfs_pkg::CMD_EVENT: begin
        len = {1'b0, cur.vlq_len} + 4'd2 + {3'd0, cur.two_data};
        if (idx < {1'b0, cur.vlq_len}) begin
          // continuation flag on every group but the last
          byte_val = {(grp_sel != 3'd0), grp};
        end else begin
          unique case (tail_idx)
            4'd0:    byte_val = cur.status;
            4'd1:    byte_val = {1'b0, cur.data1};
            default: byte_val = {1'b0, cur.data2};
          endcase
        end
      end
      default: begin
        len      = 4'd1;
        byte_val = 8'h00;
      end
    endcase
  end

  assign final_byte = (idx == len - 4'd1);
  assign adv        = !ov || trk.ready;
  assign emit       = busy && adv;
  assign pop_ready  = !busy || (emit && final_byte);
  assign take       = pop_valid && pop_ready;
  // a start request restarts the track length
  assign base       = ((cur.kind == smfs_pkg::CMD_START) && (idx == 4'd0)) ? 32'd0 : cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ov   <= 1'b0;
      idx  <= 4'd0;
      cnt  <= 32'd0;
    end else begin
      if (adv) ov <= busy;
      if (emit) begin
        cnt <= base + 32'd1;
        idx <= idx + 4'd1;
        if (final_byte) busy <= 1'b0;
      end
      if (take) begin
        busy <= 1'b1;
        idx  <= 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      obyte <= byte_val;
      olast <= final_byte;
    end
    if (take) cur <= pop_data;
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx < len))
    else $error("byte index ran past the request length");

  a_start_count: assert property (@(posedge clk) disable iff (rst)
    (emit && (cur.kind == smfs_pkg::CMD_START) && (idx == 4'd0)) |=> (cnt == 32'd1))
    else $error("track length not restarted by start request");

  a_start_len: assert property (@(posedge clk) disable iff (rst)
    (emit && final_byte && (cur.kind == smfs_pkg::CMD_START)) |=> (cnt == 32'd7))
    else $error("tempo meta event length mismatch");

endmodule

// ===== hdl/midi_event_to_smf_track_serializer_top.sv =====
// channel  dir  handshake          payload
// evt      in   valid/ready        mode, tick, status, data1, data2
// trk      out  valid/ready        out_byte, last, track_bytes
//
// one output byte per cycle while trk.ready is high; request lengths in bytes:
// start 7, end 4, event 3 to 8 (vlq length plus status and one or two data bytes)
// the byte writer is the bottleneck; requests queue between decoder and writer
// input is taken every cycle while the queue has room, dropped events included
// rst is synchronous and clears the queue, the first-event flag and the byte count
// the output register holds its byte while trk.ready is low
module midi_event_to_smf_track_serializer_top #(
  parameter int QUEUE_DEPTH = smfs_pkg::QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  smfs_evt_if.sink   evt,
  smfs_trk_if.source trk
);

  logic           push_valid;
  logic           push_ready;
  smfs_pkg::cmd_t push_data;
  logic           pop_valid;
  logic           pop_ready;
  smfs_pkg::cmd_t pop_data;

  smfs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .evt        (evt),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  smfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  smfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .trk       (trk)
  );

endmodule
